[hdl/rsft_pkg.sv]
`timescale 1ns / 1ps
package rsft_pkg;

  localparam int unsigned KeyW = 4;
  localparam int unsigned OpW = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_JOIN   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_DUP_JOIN  = 2'd1,
    ST_ABSENT    = 2'd2,
    ST_LOCAL_RM  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic out_free;
    logic local_present;
  } sts_t;

endpackage

[hdl/ring_successor_finger_table.sv]
`timescale 1ns / 1ps
// successor ring over 2^RING_BITS keys: one presence bit per key, local node always present.
// fingers and predecessors are a pure function of membership, so a lookup returns the
// successor by walking the presence bits clockwise from the key, one key per cycle; this
// is where finger routing always ends up. join and remove go from the scan state straight
// to the result register once the output register is free; a lookup first steps the cursor
// over d keys, d being the clockwise distance from the key to its successor (at most
// 2^RING_BITS - 1). the input is ready again as soon as the result is loaded, when the
// controller returns to idle. one item in flight at a time; a finished result waits in the
// output register while the next item is taken, and that item holds at its last step
// until the output register is free. writing local_key resets the ring to hold only the
// new local node.
module ring_successor_finger_table #(
  parameter int unsigned RING_BITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rsft_pkg::OpW-1:0]      op_i,
  input  logic [rsft_pkg::KeyW-1:0]     key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rsft_pkg::StatusW-1:0]  status_o,
  output logic [rsft_pkg::KeyW-1:0]     result_key_o,
  output logic                          is_local_o,
  input  logic                          cfg_we_i,
  input  logic [rsft_pkg::KeyW-1:0]     cfg_local_key_i
);
  import rsft_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing: idle -> scan -> idle
  rsft_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // membership bits, scan cursor and result register
  rsft_dp #(
    .RING_BITS (RING_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op_i),
    .key_i           (key_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_local_key_i (cfg_local_key_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .result_key_o    (result_key_o),
    .is_local_o      (is_local_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

`ifndef NO_ASSERTIONS
  // local node can never leave the ring, which bounds every scan
  a_local_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.local_present) else $error("local node missing from ring");

  // a result is only written into a free output register
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (sts.hit && sts.out_free)) else $error("finish without hit or room");

  // a finish always raises output valid
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o) else $error("result lost");

  // no new transfer while an item is being processed
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !in_ready_o) else $error("input taken mid-scan");
`endif

endmodule

[hdl/rsft_ctrl.sv]
`timescale 1ns / 1ps
module rsft_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rsft_pkg::sts_t sts_i,
  output rsft_pkg::cmd_t cmd_o
);
  import rsft_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.hit && sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == S_IDLE);
    cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.step    = (state_q == S_SCAN) && !sts_i.hit;
    cmd_o.finish  = (state_q == S_SCAN) && sts_i.hit && sts_i.out_free;
  end

endmodule

[hdl/rsft_dp.sv]
`timescale 1ns / 1ps
module rsft_dp #(
  parameter int unsigned RING_BITS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rsft_pkg::OpW-1:0]      op_i,
  input  logic [rsft_pkg::KeyW-1:0]     key_i,
  input  logic                          cfg_we_i,
  input  logic [rsft_pkg::KeyW-1:0]     cfg_local_key_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rsft_pkg::StatusW-1:0]  status_o,
  output logic [rsft_pkg::KeyW-1:0]     result_key_o,
  output logic                          is_local_o,
  input  rsft_pkg::cmd_t                cmd_i,
  output rsft_pkg::sts_t                sts_o
);
  import rsft_pkg::*;

  localparam int unsigned Space = 1 << RING_BITS;

  logic [Space-1:0]     present_q, present_d;
  logic [RING_BITS-1:0] local_q;
  op_e                  op_q;
  logic [RING_BITS-1:0] key_q;
  logic [RING_BITS-1:0] cursor_q;
  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [KeyW-1:0]      rkey_q, rkey_d;
  logic                 loc_q, loc_d;

  always_comb begin
    sts_o.hit           = (op_q != OP_LOOKUP) || present_q[cursor_q];
    sts_o.out_free      = !out_valid_q || out_ready_i;
    sts_o.local_present = present_q[local_q];
  end

  // membership update and response on finish
  always_comb begin
    present_d = present_q;
    status_d  = ST_OK;
    rkey_d    = KeyW'(key_q);
    loc_d     = 1'b0;
    unique case (op_q)
      OP_JOIN: begin
        if (present_q[key_q]) status_d = ST_DUP_JOIN;
        else present_d[key_q] = 1'b1;
      end
      OP_REMOVE: begin
        if (key_q == local_q) status_d = ST_LOCAL_RM;
        else if (!present_q[key_q]) status_d = ST_ABSENT;
        else present_d[key_q] = 1'b0;
      end
      OP_LOOKUP: begin
        rkey_d = KeyW'(cursor_q);
        loc_d  = (cursor_q == local_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q     <= '0;
      present_q   <= Space'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        local_q   <= RING_BITS'(cfg_local_key_i);
        present_q <= Space'(1) << RING_BITS'(cfg_local_key_i);
      end else if (cmd_i.finish) begin
        present_q <= present_d;
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_e'(op_i);
      key_q    <= RING_BITS'(key_i);
      cursor_q <= RING_BITS'(key_i);
    end else if (cmd_i.step) begin
      cursor_q <= cursor_q + 1'b1;
    end
    if (cmd_i.finish) begin
      status_q <= status_d;
      rkey_q   <= rkey_d;
      loc_q    <= loc_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign result_key_o = rkey_q;
  assign is_local_o   = loc_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
  import rsft_pkg::*;

  localparam int unsigned NKeys = 1 << KeyW;
  localparam int unsigned SettleCycles = 32;   // wait after the last result so the block is idle
  localparam int unsigned StallLimit = 5000;   // cycles without any transfer
  localparam int unsigned HoldCycles = 300;    // long receiver hold-off

  // one expected result
  typedef struct packed {
    status_e           status;
    logic [KeyW-1:0]   rkey;
    logic              loc;
  } ring_result_t;

  // directed stimulus row; has_exp marks rows with a hand-written result
  typedef struct packed {
    op_e               op;
    logic [KeyW-1:0]   key;
    logic              has_exp;
    status_e           status;
    logic [KeyW-1:0]   rkey;
    logic              loc;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OpW-1:0] op_drv = OP_NONE;
  logic [KeyW-1:0] key_drv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [StatusW-1:0] status_out;
  logic [KeyW-1:0] rkey_out;
  logic is_local_out;
  logic cfg_we = 1'b0;
  logic [KeyW-1:0] cfg_key = '0;

  // predictor state: membership bitmap and the local node
  logic [NKeys-1:0] member_map;
  logic [KeyW-1:0] home_key;

  ring_result_t pending_q[$];
  int errors = 0;
  int send_idle_pct = 0;     // chance of an idle gap before each transfer
  int recv_stall_pct = 0;    // chance the receiver stalls in a cycle
  bit hold_request = 1'b0;   // asks the receiver for one long hold-off
  int hold_left = 0;         // cycles left in the current hold-off
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  ring_successor_finger_table #(.RING_BITS(KeyW)) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op_drv),
    .key_i          (key_drv),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .status_o       (status_out),
    .result_key_o   (rkey_out),
    .is_local_o     (is_local_out),
    .cfg_we_i       (cfg_we),
    .cfg_local_key_i(cfg_key)
  );

  // --- ring predictor ---

  // first member clockwise from k, k included
  function automatic logic [KeyW-1:0] successor_of(logic [KeyW-1:0] k);
    logic [KeyW-1:0] c;
    for (int d = 0; d < NKeys; d++) begin
      c = k + KeyW'(d);
      if (member_map[c]) return c;
    end
    return home_key;
  endfunction

  // finger i of node n: successor of n + 2^i
  function automatic logic [KeyW-1:0] finger_of(logic [KeyW-1:0] n, int i);
    return successor_of(n + KeyW'(1 << i));
  endfunction

  // k strictly inside (a, b) clockwise; empty when a == b
  function automatic bit between_open(logic [KeyW-1:0] k, logic [KeyW-1:0] a,
                                      logic [KeyW-1:0] b);
    if (a < b) return (a < k) && (k < b);
    if (a > b) return (k > a) || (k < b);
    return 1'b0;
  endfunction

  // finger routing from the local node, hop by hop
  function automatic logic [KeyW-1:0] route_key(logic [KeyW-1:0] k);
    logic [KeyW-1:0] n;
    logic [KeyW-1:0] s;
    logic [KeyW-1:0] nxt;
    logic [KeyW-1:0] f;
    n = home_key;
    if (k == n) return n;
    for (int hop = 0; hop < NKeys; hop++) begin
      s = finger_of(n, 0);
      // (n, s], the whole ring when n == s
      if (n == s || k == s || between_open(k, n, s)) return s;
      nxt = n;
      for (int i = KeyW - 1; i >= 0; i--) begin
        f = finger_of(n, i);
        if (between_open(f, n, k)) begin
          nxt = f;
          break;
        end
      end
      if (nxt == n) return s;
      n = nxt;
    end
    return finger_of(n, 0);
  endfunction

  // applies one item to the predicted ring and returns its result
  function automatic ring_result_t apply_ring_op(op_e op, logic [KeyW-1:0] k);
    ring_result_t r;
    r.status = ST_OK;
    r.rkey = k;
    r.loc = 1'b0;
    case (op)
      OP_JOIN: begin
        if (member_map[k]) r.status = ST_DUP_JOIN;
        else member_map[k] = 1'b1;
      end
      OP_REMOVE: begin
        if (k == home_key) r.status = ST_LOCAL_RM;
        else if (!member_map[k]) r.status = ST_ABSENT;
        else member_map[k] = 1'b0;
      end
      OP_LOOKUP: begin
        r.rkey = route_key(k);
        r.loc = (r.rkey == home_key);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void reset_ring(logic [KeyW-1:0] k);
    home_key = k;
    member_map = '0;
    member_map[k] = 1'b1;
  endfunction

  // --- sender ---

  // offers one transfer, optionally with a hand-written expectation
  task automatic send_item(op_e op, logic [KeyW-1:0] k, bit has_exp,
                           ring_result_t typed);
    ring_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op_drv <= op;
    key_drv <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_ring_op(op, k);
    pending_q.push_back(has_exp ? typed : r);
  endtask

  task automatic send_random(int count);
    int pick;
    logic [KeyW-1:0] k;
    op_e op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      k = KeyW'($urandom);
      if (pick < 35) op = OP_JOIN;
      else if (pick < 65) begin
        op = OP_REMOVE;
        // mostly remove a real member so the ring keeps changing
        if ($urandom_range(3) != 0) begin
          for (int t = 0; t < 8 && !member_map[k]; t++) k = KeyW'($urandom);
        end
      end else if (pick < 95) op = OP_LOOKUP;
      else op = OP_NONE;
      send_item(op, k, 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic write_local_key(logic [KeyW-1:0] k);
    drain_results();
    cfg_we <= 1'b1;
    cfg_key <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
    reset_ring(k);
    @(posedge clk);
  endtask

  // --- receiver: checks and drives ready ---
  always @(posedge clk) begin
    ring_result_t exp_r;
    if (out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no expectation: status %0d key %0d", status_out, rkey_out);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (status_out !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_out);
          errors++;
        end
        if (rkey_out !== exp_r.rkey) begin
          $error("result_key: expected %0d, got %0d", exp_r.rkey, rkey_out);
          errors++;
        end
        if (is_local_out !== exp_r.loc) begin
          $error("is_local: expected %0d, got %0d", exp_r.loc, is_local_out);
          errors++;
        end
      end
    end
    if (hold_request && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --- main sequence ---
  directed_row_t directed_rows[$];

  initial begin
    ring_result_t typed;
    reset_ring('0);
    // local node 0 after reset; typed rows read straight off the ring
    directed_rows = '{
      '{OP_LOOKUP, 4'd0,  1'b1, ST_OK,       4'd0,  1'b1},
      '{OP_LOOKUP, 4'd15, 1'b1, ST_OK,       4'd0,  1'b1},
      '{OP_REMOVE, 4'd0,  1'b1, ST_LOCAL_RM, 4'd0,  1'b0},
      '{OP_REMOVE, 4'd5,  1'b1, ST_ABSENT,   4'd5,  1'b0},
      '{OP_NONE,   4'd9,  1'b1, ST_OK,       4'd9,  1'b0},
      '{OP_JOIN,   4'd5,  1'b1, ST_OK,       4'd5,  1'b0},
      '{OP_JOIN,   4'd5,  1'b1, ST_DUP_JOIN, 4'd5,  1'b0},
      '{OP_JOIN,   4'd15, 1'b1, ST_OK,       4'd15, 1'b0},
      '{OP_JOIN,   4'd0,  1'b1, ST_DUP_JOIN, 4'd0,  1'b0},
      '{OP_LOOKUP, 4'd3,  1'b0, ST_OK,       4'd0,  1'b0},
      '{OP_LOOKUP, 4'd6,  1'b0, ST_OK,       4'd0,  1'b0},
      '{OP_LOOKUP, 4'd15, 1'b0, ST_OK,       4'd0,  1'b0},
      '{OP_LOOKUP, 4'd1,  1'b0, ST_OK,       4'd0,  1'b0},
      '{OP_JOIN,   4'd10, 1'b0, ST_OK,       4'd0,  1'b0},
      '{OP_LOOKUP, 4'd11, 1'b0, ST_OK,       4'd0,  1'b0},
      '{OP_REMOVE, 4'd15, 1'b1, ST_OK,       4'd15, 1'b0},
      '{OP_REMOVE, 4'd15, 1'b1, ST_ABSENT,   4'd15, 1'b0},
      '{OP_LOOKUP, 4'd12, 1'b0, ST_OK,       4'd0,  1'b0},
      '{OP_NONE,   4'd15, 1'b1, ST_OK,       4'd15, 1'b0},
      '{OP_LOOKUP, 4'd8,  1'b0, ST_OK,       4'd0,  1'b0}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      typed.status = directed_rows[i].status;
      typed.rkey = directed_rows[i].rkey;
      typed.loc = directed_rows[i].loc;
      send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].has_exp, typed);
    end
    in_valid <= 1'b0;
    // sender waits for every result before going on
    while (pending_q.size() != 0) @(posedge clk);

    // no idling, with one long receiver hold-off to back up the input
    send_random(60);
    hold_request = 1'b1;
    send_random(340);

    write_local_key(4'd15);
    send_idle_pct = 76;
    send_random(390);

    write_local_key(KeyW'($urandom_range(1, 14)));
    send_idle_pct = 0;
    recv_stall_pct = 76;
    send_random(390);

    write_local_key(4'd0);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    send_random(390);

    write_local_key(4'd7);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(390);

    drain_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
